// ===== hw/rtl/dhqp_pkg.sv =====
`default_nettype none

package dhqp_pkg;

  // name length in bytes at which the parse is aborted
  localparam int unsigned NAME_LIMIT = 256;
  localparam int unsigned NAME_CNT_W = $clog2(NAME_LIMIT + 1);

  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned HDR_WORDS = HDR_BYTES / 2;
  localparam int unsigned HDR_IDX_W = 4;
  localparam int unsigned HDR_WORD_W = $clog2(HDR_WORDS);

  // header word positions
  localparam logic [HDR_WORD_W-1:0] W_ID    = HDR_WORD_W'(0);
  localparam logic [HDR_WORD_W-1:0] W_FLAGS = HDR_WORD_W'(1);
  localparam logic [HDR_WORD_W-1:0] W_QD    = HDR_WORD_W'(2);
  localparam logic [HDR_WORD_W-1:0] W_AN    = HDR_WORD_W'(3);
  localparam logic [HDR_WORD_W-1:0] W_NS    = HDR_WORD_W'(4);

  localparam logic [HDR_IDX_W-1:0] IDX_FLAGS_LO = HDR_IDX_W'(3);
  localparam logic [HDR_IDX_W-1:0] IDX_HDR_END  = HDR_IDX_W'(HDR_BYTES - 1);

  localparam int unsigned Z_BIT     = 6;
  localparam logic [7:0]  DOT_CHAR  = 8'h2e;

  typedef enum logic [2:0] {
    KIND_HEADER      = 3'd0,
    KIND_NAME_CHAR   = 3'd1,
    KIND_QUESTION    = 3'd2,
    KIND_RSVD_ABORT  = 3'd3,
    KIND_LONG_ABORT  = 3'd4,
    KIND_TRUNC_ABORT = 3'd5
  } kind_t;

  // one accepted input transaction
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } stage_t;

  // one result transaction
  typedef struct packed {
    kind_t       kind;
    logic [15:0] msg_id;
    logic        is_response;
    logic [3:0]  opcode;
    logic [3:0]  rcode;
    logic [15:0] qd_count;
    logic [15:0] an_count;
    logic [15:0] ns_count;
    logic [15:0] additional_count;
    logic [7:0]  name_char;
    logic [31:0] type_and_class;
    logic        finished;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dhqp_in_reg.sv =====
`default_nettype none

module dhqp_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last_byte,
  input  wire logic            fwd_ready,
  output logic                 in_stall,
  output dhqp_pkg::stage_t     stage
);
  import dhqp_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // held only when a byte waits and the parser cannot move on
  assign in_stall = valid_r && !fwd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign stage = '{valid: valid_r, data_byte: byte_r, last_byte: last_r};

endmodule

`default_nettype wire

// ===== hw/rtl/dhqp_parse.sv =====
`default_nettype none

module dhqp_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dhqp_pkg::stage_t stage,
  input  wire logic             step,
  output logic                  res_valid,
  output dhqp_pkg::result_t     res
);
  import dhqp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME_START,
    PH_NAME,
    PH_TYPECLASS,
    PH_SKIP
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [HDR_IDX_W-1:0]   hdr_idx_r, hdr_idx_nxt;
  logic [7:0]             hi_byte_r, hi_byte_nxt;
  logic [15:0]            hw_r [HDR_WORDS];
  logic                   hw_we;
  logic [HDR_WORD_W-1:0]  hw_sel;
  logic [7:0]             label_r, label_nxt;
  logic [NAME_CNT_W-1:0]  name_bytes_r, name_bytes_nxt;
  logic [NAME_CNT_W-1:0]  name_inc;
  logic [15:0]            qs_r, qs_nxt;
  logic [15:0]            qs_inc;
  logic [23:0]            tc_shift_r, tc_shift_nxt;
  logic [1:0]             tc_idx_r, tc_idx_nxt;
  logic                   do_finish;
  logic [7:0]             b;
  logic                   last;

  assign b        = stage.data_byte;
  assign last     = stage.last_byte;
  assign hw_sel   = hdr_idx_r[HDR_IDX_W-1:1];
  assign name_inc = name_bytes_r + NAME_CNT_W'(1);
  assign qs_inc   = qs_r + 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    hi_byte_nxt    = hi_byte_r;
    hw_we          = 1'b0;
    label_nxt      = label_r;
    name_bytes_nxt = name_bytes_r;
    qs_nxt         = qs_r;
    tc_shift_nxt   = tc_shift_r;
    tc_idx_nxt     = tc_idx_r;
    do_finish      = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    case (phase_r)
      PH_HEADER: begin
        hdr_idx_nxt = hdr_idx_r + HDR_IDX_W'(1);
        if (!hdr_idx_r[0]) begin
          hi_byte_nxt = b;
        end else begin
          hw_we = 1'b1;
        end
        if (hdr_idx_r == IDX_FLAGS_LO && b[Z_BIT]) begin
          res_valid    = 1'b1;
          res.kind     = KIND_RSVD_ABORT;
          res.finished = 1'b1;
          do_finish    = 1'b1;
        end else if (hdr_idx_r < IDX_HDR_END) begin
          if (last) begin
            res_valid    = 1'b1;
            res.kind     = KIND_TRUNC_ABORT;
            res.finished = 1'b1;
            do_finish    = 1'b1;
          end
        end else begin
          res_valid            = 1'b1;
          res.kind             = KIND_HEADER;
          res.msg_id           = hw_r[W_ID];
          res.is_response      = hw_r[W_FLAGS][15];
          res.opcode           = hw_r[W_FLAGS][14:11];
          res.rcode            = hw_r[W_FLAGS][3:0];
          res.qd_count         = hw_r[W_QD];
          res.an_count         = hw_r[W_AN];
          res.ns_count         = hw_r[W_NS];
          res.additional_count = {hi_byte_r, b};
          res.finished         = (hw_r[W_QD] == 16'd0) || last;
          if (res.finished) begin
            do_finish = 1'b1;
          end else begin
            phase_nxt      = PH_NAME_START;
            name_bytes_nxt = '0;
            label_nxt      = '0;
          end
        end
      end

      PH_NAME_START, PH_NAME: begin
        if (b == 8'd0) begin
          // end of name
          phase_nxt    = PH_TYPECLASS;
          tc_shift_nxt = '0;
          tc_idx_nxt   = '0;
          if (last) begin
            res_valid    = 1'b1;
            res.kind     = KIND_TRUNC_ABORT;
            res.finished = 1'b1;
            do_finish    = 1'b1;
          end
        end else begin
          name_bytes_nxt = name_inc;
          if (name_inc >= NAME_CNT_W'(NAME_LIMIT)) begin
            res_valid    = 1'b1;
            res.kind     = KIND_LONG_ABORT;
            res.finished = 1'b1;
            do_finish    = 1'b1;
          end else if (last) begin
            res_valid    = 1'b1;
            res.kind     = KIND_TRUNC_ABORT;
            res.finished = 1'b1;
            do_finish    = 1'b1;
          end else if (phase_r == PH_NAME_START) begin
            label_nxt = b;
            phase_nxt = PH_NAME;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_NAME_CHAR;
            if (label_r == 8'd0) begin
              label_nxt     = b;
              res.name_char = DOT_CHAR;
            end else begin
              label_nxt     = label_r - 8'd1;
              res.name_char = b;
            end
          end
        end
      end

      PH_TYPECLASS: begin
        tc_shift_nxt = {tc_shift_r[15:0], b};
        tc_idx_nxt   = tc_idx_r + 2'd1;
        if (tc_idx_r != 2'd3) begin
          if (last) begin
            res_valid    = 1'b1;
            res.kind     = KIND_TRUNC_ABORT;
            res.finished = 1'b1;
            do_finish    = 1'b1;
          end
        end else begin
          qs_nxt             = qs_inc;
          res_valid          = 1'b1;
          res.kind           = KIND_QUESTION;
          res.type_and_class = {tc_shift_r, b};
          res.finished       = (qs_inc == hw_r[W_QD]) || last;
          if (res.finished) begin
            do_finish = 1'b1;
          end else begin
            phase_nxt      = PH_NAME_START;
            name_bytes_nxt = '0;
            label_nxt      = '0;
            tc_shift_nxt   = '0;
            tc_idx_nxt     = '0;
          end
        end
      end

      PH_SKIP: begin
        // ignore the rest of the packet
        if (last) begin
          do_finish = 1'b1;
        end
      end

      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    if (do_finish) begin
      phase_nxt      = last ? PH_HEADER : PH_SKIP;
      hdr_idx_nxt    = '0;
      label_nxt      = '0;
      name_bytes_nxt = '0;
      qs_nxt         = '0;
      tc_shift_nxt   = '0;
      tc_idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_idx_r    <= '0;
      hi_byte_r    <= '0;
      label_r      <= '0;
      name_bytes_r <= '0;
      qs_r         <= '0;
      tc_shift_r   <= '0;
      tc_idx_r     <= '0;
      for (int i = 0; i < HDR_WORDS; i++) begin
        hw_r[i] <= '0;
      end
    end else if (step) begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      hi_byte_r    <= hi_byte_nxt;
      label_r      <= label_nxt;
      name_bytes_r <= name_bytes_nxt;
      qs_r         <= qs_nxt;
      tc_shift_r   <= tc_shift_nxt;
      tc_idx_r     <= tc_idx_nxt;
      for (int i = 0; i < HDR_WORDS; i++) begin
        if (hw_we && hw_sel == HDR_WORD_W'(i)) begin
          hw_r[i] <= {hi_byte_r, b};
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dhqp_out_reg.sv =====
`default_nettype none

module dhqp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              res_valid,
  input  wire dhqp_pkg::result_t res,
  input  wire logic              out_stall,
  output logic                   fwd_ready,
  output logic                   out_valid,
  output dhqp_pkg::result_t      out_res
);
  import dhqp_pkg::*;

  logic    valid_r;
  result_t res_r;

  // register is free when empty or being taken this cycle
  assign fwd_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fwd_ready) begin
      valid_r <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_ready && load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dns_header_question_parser.sv =====
// dns header and question parser
//
// input channel: one payload byte per transaction (in_data_byte), with
// in_last_byte marking the final byte of a packet. in_valid/in_stall.
// result channel: at most one result transaction per input byte, kind
// selects header, name character, question done or one of three aborts;
// fields not belonging to that kind read as zero. out_valid/out_stall.
//
// a taken byte passes through one input register and one result register on
// its way out, with the combinational parse step between the two registers.
// throughput: one byte every cycle while the receiver does not stall.
//
// the result register frees up in the same cycle it is taken, so a new byte
// is accepted while an earlier result is still waiting. if the receiver
// stalls, the parser holds its byte and in_stall rises; nothing is dropped.
//
// reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of the header with all counters cleared.

`default_nettype none

module dns_header_question_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [15:0]      out_msg_id,
  output logic             out_is_response,
  output logic [3:0]       out_opcode,
  output logic [3:0]       out_rcode,
  output logic [15:0]      out_qd_count,
  output logic [15:0]      out_an_count,
  output logic [15:0]      out_ns_count,
  output logic [15:0]      out_additional_count,
  output logic [7:0]       out_name_char,
  output logic [31:0]      out_type_and_class,
  output logic             out_finished
);
  import dhqp_pkg::*;

  stage_t  stage;
  logic    fwd_ready;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // a held byte moves through the parser once the result register is free
  assign step = stage.valid && fwd_ready;

  dhqp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .fwd_ready    (fwd_ready),
    .in_stall     (in_stall),
    .stage        (stage)
  );

  // header, name and question state machine
  dhqp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  dhqp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .fwd_ready (fwd_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // unpack the result transaction onto its ports
  assign out_kind             = out_res.kind;
  assign out_msg_id           = out_res.msg_id;
  assign out_is_response      = out_res.is_response;
  assign out_opcode           = out_res.opcode;
  assign out_rcode            = out_res.rcode;
  assign out_qd_count         = out_res.qd_count;
  assign out_an_count         = out_res.an_count;
  assign out_ns_count         = out_res.ns_count;
  assign out_additional_count = out_res.additional_count;
  assign out_name_char        = out_res.name_char;
  assign out_type_and_class   = out_res.type_and_class;
  assign out_finished         = out_res.finished;

endmodule

`default_nettype wire

// ===== hw/rtl/dhqp_checker.sv =====
`default_nettype none

module dhqp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_data_byte,
  input wire logic        in_last_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_kind,
  input wire logic [15:0] out_msg_id,
  input wire logic        out_is_response,
  input wire logic [3:0]  out_opcode,
  input wire logic [3:0]  out_rcode,
  input wire logic [15:0] out_qd_count,
  input wire logic [15:0] out_an_count,
  input wire logic [15:0] out_ns_count,
  input wire logic [15:0] out_additional_count,
  input wire logic [7:0]  out_name_char,
  input wire logic [31:0] out_type_and_class,
  input wire logic        out_finished
);
  import dhqp_pkg::*;

  // every abort ends the packet
  a_abort_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_RSVD_ABORT || out_kind == KIND_LONG_ABORT ||
                  out_kind == KIND_TRUNC_ABORT) |-> out_finished)
    else $error("abort without finished");

  // name characters never end the packet and are never zero bytes
  a_name_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NAME_CHAR
      |-> !out_finished && out_name_char != 8'd0 && out_type_and_class == 32'd0)
    else $error("bad name character transaction");

  // header fields are zero outside the header transaction
  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_HEADER
      |-> out_msg_id == 16'd0 && out_qd_count == 16'd0 && out_an_count == 16'd0 &&
          out_ns_count == 16'd0 && out_additional_count == 16'd0 &&
          !out_is_response && out_opcode == 4'd0 && out_rcode == 4'd0)
    else $error("header fields outside header transaction");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_finished))
    else $error("stalled result changed");

  // a stalled input byte stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall
      |=> in_valid && $stable(in_data_byte) && $stable(in_last_byte))
    else $error("stalled input changed");

endmodule

bind dns_header_question_parser dhqp_checker u_dhqp_checker (.*);

`default_nettype wire

// ===== tb/dns_header_question_parser_tb.sv =====
`default_nettype none

module dns_header_question_parser_tb;
  import dhqp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 430;
  // result register plus the longest receiver stall, with margin
  localparam int unsigned DRAIN_CYCLES = 24;

  // where the parse of the current packet stands
  typedef enum logic [2:0] {
    AT_HEADER,
    AT_NAME_START,
    AT_NAME,
    AT_TYPE_CLASS,
    SKIPPING
  } parse_at_t;

  // one payload byte waiting to be offered, with its idle cycles ahead of it
  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
  } payload_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_msg_id;
  logic        out_is_response;
  logic [3:0]  out_opcode;
  logic [3:0]  out_rcode;
  logic [15:0] out_qd_count;
  logic [15:0] out_an_count;
  logic [15:0] out_ns_count;
  logic [15:0] out_additional_count;
  logic [7:0]  out_name_char;
  logic [31:0] out_type_and_class;
  logic        out_finished;

  dns_header_question_parser DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_msg_id           (out_msg_id),
    .out_is_response      (out_is_response),
    .out_opcode           (out_opcode),
    .out_rcode            (out_rcode),
    .out_qd_count         (out_qd_count),
    .out_an_count         (out_an_count),
    .out_ns_count         (out_ns_count),
    .out_additional_count (out_additional_count),
    .out_name_char        (out_name_char),
    .out_type_and_class   (out_type_and_class),
    .out_finished         (out_finished)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // byte stream still to be offered, and the parse results owed by the block
  payload_byte_t payload_bytes[$];
  result_t       parse_results[$];
  logic [7:0]    pkt[$];

  // running counts for the end summary and the finish condition
  int unsigned cycles = 0;
  int unsigned bytes_total = 0;
  int unsigned bytes_taken = 0;
  int unsigned packets = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned kind_count[6];

  logic        in_taken = 1'b0;
  int unsigned idle_count = 0;
  int unsigned stall_left = 0;

  // our own copy of the parser state
  parse_at_t             parse_at;
  logic [HDR_IDX_W-1:0]  hdr_idx;
  logic [15:0]           hdr_word [HDR_WORDS];
  logic [7:0]            label_left;
  logic [NAME_CNT_W-1:0] name_len;
  logic [15:0]           questions_done;
  logic [31:0]           tc_shift;
  logic [1:0]            tc_idx;

  // wait cycles for one transaction: none in calm stretches, else a mix that
  // is mostly short with the occasional long one
  function automatic int unsigned draw_wait(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 17);
      1:       return $urandom_range(0, 2);
      default: return 0;
    endcase
  endfunction

  task automatic clear_parse();
    hdr_idx = '0;
    foreach (hdr_word[i]) hdr_word[i] = 16'h0000;
    label_left = 8'h00;
    name_len = '0;
    questions_done = 16'h0000;
    tc_shift = 32'h0;
    tc_idx = 2'd0;
  endtask

  // a finish on a last byte starts the next packet at once, otherwise the
  // rest of the packet is skipped up to its last byte
  task automatic close_packet(input logic last);
    clear_parse();
    parse_at = last ? AT_HEADER : SKIPPING;
  endtask

  task automatic abort_packet(input kind_t k, input logic last);
    result_t r;
    r = '0;
    r.kind = k;
    r.finished = 1'b1;
    parse_results.push_back(r);
    close_packet(last);
  endtask

  // steps the parse by one accepted byte and queues the result it gives
  task automatic parse_byte(input logic [7:0] b, input logic last);
    result_t          r;
    logic [HDR_IDX_W-1:0] idx;
    logic [1:0]       k;
    logic [15:0]      flags;
    logic             fin;
    int               w;
    r = '0;
    case (parse_at)
      AT_HEADER: begin
        idx = hdr_idx;
        w = int'(idx >> 1) % 6;
        if (!idx[0]) begin
          hdr_word[w] = {b, 8'h00};
        end else begin
          hdr_word[w][7:0] = b;
        end
        hdr_idx = idx + 4'd1;
        flags = hdr_word[W_FLAGS];
        if (idx == IDX_FLAGS_LO && flags[Z_BIT]) begin
          // reserved bit wins over a last byte on the same flags byte
          abort_packet(KIND_RSVD_ABORT, last);
        end else if (idx < IDX_HDR_END) begin
          if (last) abort_packet(KIND_TRUNC_ABORT, last);
        end else begin
          fin = (hdr_word[W_QD] == 16'h0000) || last;
          r.kind = KIND_HEADER;
          r.msg_id = hdr_word[W_ID];
          r.is_response = flags[15];
          r.opcode = flags[14:11];
          r.rcode = flags[3:0];
          r.qd_count = hdr_word[W_QD];
          r.an_count = hdr_word[W_AN];
          r.ns_count = hdr_word[W_NS];
          r.additional_count = hdr_word[HDR_WORDS-1];
          r.finished = fin;
          parse_results.push_back(r);
          if (fin) begin
            close_packet(last);
          end else begin
            parse_at = AT_NAME_START;
            name_len = '0;
            label_left = 8'h00;
          end
        end
      end
      AT_NAME_START, AT_NAME: begin
        if (b == 8'h00) begin
          // end of name, an empty one when it is the first byte
          parse_at = AT_TYPE_CLASS;
          tc_shift = 32'h0;
          tc_idx = 2'd0;
          if (last) abort_packet(KIND_TRUNC_ABORT, last);
        end else begin
          name_len = name_len + NAME_CNT_W'(1);
          if (name_len >= NAME_LIMIT) begin
            // too long wins over a last byte here
            abort_packet(KIND_LONG_ABORT, last);
          end else if (last) begin
            abort_packet(KIND_TRUNC_ABORT, last);
          end else if (parse_at == AT_NAME_START) begin
            // first length byte gives no character
            label_left = b;
            parse_at = AT_NAME;
          end else begin
            r.kind = KIND_NAME_CHAR;
            if (label_left == 8'h00) begin
              label_left = b;
              r.name_char = DOT_CHAR;
            end else begin
              r.name_char = b;
              label_left = label_left - 8'd1;
            end
            parse_results.push_back(r);
          end
        end
      end
      AT_TYPE_CLASS: begin
        k = tc_idx;
        tc_shift = {tc_shift[23:0], b};
        tc_idx = k + 2'd1;
        if (k != 2'd3) begin
          if (last) abort_packet(KIND_TRUNC_ABORT, last);
        end else begin
          questions_done = questions_done + 16'd1;
          fin = (questions_done == hdr_word[W_QD]) || last;
          r.kind = KIND_QUESTION;
          r.type_and_class = tc_shift;
          r.finished = fin;
          parse_results.push_back(r);
          if (fin) begin
            close_packet(last);
          end else begin
            parse_at = AT_NAME_START;
            name_len = '0;
            label_left = 8'h00;
            tc_shift = 32'h0;
            tc_idx = 2'd0;
          end
        end
      end
      default: begin
        if (last) begin
          clear_parse();
          parse_at = AT_HEADER;
        end
      end
    endcase
  endtask

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // packet assembly: bytes gather in pkt, then go out with last on one of them
  task automatic put_word(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] qd, input logic [15:0] an,
                            input logic [15:0] ns, input logic [15:0] ar);
    put_word(id);
    put_word(flags);
    put_word(qd);
    put_word(an);
    put_word(ns);
    put_word(ar);
  endtask

  // labels are mostly short, now and then up to 63; a rare zero inside a
  // label cuts the name early
  task automatic put_question();
    int unsigned labels;
    int unsigned len;
    labels = $urandom_range(0, 3);
    repeat (labels) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
      pkt.push_back(8'(len));
      repeat (len)
        pkt.push_back(($urandom_range(0, 39) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    end
    pkt.push_back(8'h00);
    repeat (4) pkt.push_back(8'($urandom));
  endtask

  task automatic ship_packet(input int unsigned last_at, input bit calm);
    payload_byte_t pb;
    int unsigned   i;
    for (i = 0; i <= last_at; i++) begin
      pb.data = pkt[i];
      pb.last = (i == last_at);
      pb.gap = draw_wait(calm);
      payload_bytes.push_back(pb);
    end
    pkt.delete();
    bytes_total += last_at + 1;
    packets++;
  endtask

  // mostly well formed packets with random content; the rest cut short,
  // flagged with the reserved bit, or plain noise
  task automatic random_packet();
    int unsigned shape;
    int unsigned nq;
    int unsigned qd;
    int unsigned cut;
    logic [15:0] flags;
    shape = $urandom_range(0, 9);
    nq = $urandom_range(0, 3);
    qd = nq;
    // more questions announced than sent: the last byte ends it on a boundary
    if ($urandom_range(0, 5) == 0) qd = nq + $urandom_range(1, 2);
    flags = 16'($urandom);
    flags[Z_BIT] = (shape == 8);
    put_header(16'($urandom), flags, 16'(qd), 16'($urandom), 16'($urandom),
               16'($urandom));
    repeat (nq) put_question();
    // trailing sections the parser is to skip
    if (shape <= 5 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
    cut = pkt.size() - 1;
    if (shape == 6 || shape == 7) cut = $urandom_range(0, pkt.size() - 1);
    if (shape == 9) begin
      pkt.delete();
      repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
      cut = pkt.size() - 1;
    end
    ship_packet(cut, $urandom_range(0, 3) == 0);
  endtask

  // driver: offers the next byte at the falling edge once the previous
  // transaction has gone, after that byte's idle cycles
  always @(negedge clk) begin : drive
    payload_byte_t pb;
    if (rst_n && (!in_valid || in_taken)) begin
      if (payload_bytes.size() != 0 && idle_count >= payload_bytes[0].gap) begin
        pb = payload_bytes.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= pb.data;
        in_last_byte <= pb.last;
        idle_count = 0;
      end else begin
        in_valid <= 1'b0;
        if (payload_bytes.size() != 0) idle_count++;
      end
    end
  end

  // receiver stall, counted down from the last result transaction
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: at the rising edge, step the parse for a taken byte first, then
  // check a result transaction against the oldest parse result owed
  always @(posedge clk) begin : sample
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d bytes taken, %0d results owed", $time,
               bytes_taken, bytes_total, parse_results.size());
      $display("FAIL");
      $finish;
    end else begin
      in_taken = rst_n && in_valid && !in_stall;
      if (in_taken) begin
        parse_byte(in_data_byte, in_last_byte);
        bytes_taken++;
      end
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        // receiver runs without stalls for one stretch in three
        stall_left = draw_wait(((results_seen / 120) % 3) == 0);
        if (parse_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 200)
            $display("%0t: result with nothing owed, kind %0d", $time, out_kind);
        end else begin
          want = parse_results.pop_front();
          kind_count[want.kind]++;
          compare_field("kind", 32'(want.kind), 32'(out_kind));
          compare_field("msg_id", 32'(want.msg_id), 32'(out_msg_id));
          compare_field("is_response", 32'(want.is_response), 32'(out_is_response));
          compare_field("opcode", 32'(want.opcode), 32'(out_opcode));
          compare_field("rcode", 32'(want.rcode), 32'(out_rcode));
          compare_field("qd_count", 32'(want.qd_count), 32'(out_qd_count));
          compare_field("an_count", 32'(want.an_count), 32'(out_an_count));
          compare_field("ns_count", 32'(want.ns_count), 32'(out_ns_count));
          compare_field("additional_count", 32'(want.additional_count),
                        32'(out_additional_count));
          compare_field("name_char", 32'(want.name_char), 32'(out_name_char));
          compare_field("type_and_class", want.type_and_class, out_type_and_class);
          compare_field("finished", 32'(want.finished), 32'(out_finished));
        end
      end
    end
  end

  initial begin
    int unsigned start_count;
    int unsigned n;
    foreach (kind_count[i]) kind_count[i] = 0;
    clear_parse();
    parse_at = AT_HEADER;

    // directed: header all ones but for the reserved bit, with no questions, finished on the header
    put_header(16'hffff, 16'hffbf, 16'h0000, 16'hffff, 16'hffff, 16'hffff);
    ship_packet(pkt.size() - 1, 1'b1);
    // reserved bit together with the last byte on the flags
    put_header(16'h0000, 16'h0040, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    ship_packet(IDX_FLAGS_LO, 1'b1);
    // one question whose name is empty, packet ends on the question boundary
    put_header(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    pkt.push_back(8'h00);
    repeat (4) pkt.push_back(8'hff);
    ship_packet(pkt.size() - 1, 1'b1);

    // names one short of the limit and right at it, the latter with last on
    // the byte that trips the limit
    for (n = NAME_LIMIT - 1; n <= NAME_LIMIT; n++) begin
      put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
      repeat (n) pkt.push_back(8'($urandom_range(1, 255)));
      pkt.push_back(8'h00);
      repeat (4) pkt.push_back(8'($urandom));
      ship_packet((n == NAME_LIMIT) ? HDR_BYTES + n - 1 : pkt.size() - 1, 1'b0);
    end

    start_count = bytes_total;
    while (bytes_total - start_count < RANDOM_BYTES) random_packet();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != bytes_total) @(negedge clk);
    while (parse_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d packets, %0d payload bytes taken, %0d results checked",
             packets, bytes_taken, results_seen);
    $display("hdr %0d, chars %0d, questions %0d, aborts rsvd %0d long %0d trunc %0d",
             kind_count[KIND_HEADER], kind_count[KIND_NAME_CHAR],
             kind_count[KIND_QUESTION], kind_count[KIND_RSVD_ABORT],
             kind_count[KIND_LONG_ABORT], kind_count[KIND_TRUNC_ABORT]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
